// ===== hdl/spmv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sparse matrix-vector multiply block.
// No dependencies; used by the top level, its checker and the testbench.
package spmv_pkg;

  // Item kind carried on the input tuser field
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_NONZERO = 2'd1;
  localparam logic [1:0] OP_CLOSE   = 2'd2;

  // Field widths fixed by the item format
  localparam int OP_W    = 2;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 16;
  localparam int PROD_W  = 32;
  localparam int SUM_W   = 48;
  localparam int ROW_W   = 10;
  localparam int CNT_W   = 11;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  // Default vector store depth
  localparam int VECTOR_LEN_DEF = 1024;

  // Reset value of the row count register
  localparam logic [CNT_W-1:0] ROWS_RESET = 11'd4;

  // Saturation limits of the row sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Result queue sizing
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCNT_W = 3;

  // One finished row, packed with the row number in the low bits
  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic [ROW_W-1:0]        row_number;
  } result_t;

endpackage

// ===== hdl/csr_sparse_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps
// A row result reaches out_tvalid through the stage 1 and stage 2 registers and the result queue.
// Throughput: one item per cycle; the vector read, the multiply and the accumulate are each one
// pipeline stage, and a four-item result queue absorbs short output stalls; input stalls once
// four results are owed. Reset (rst_n low, synchronous): pipeline, queue, accumulator and row
// counter clear, the row count returns to four; the vector store holds no data until written.
// Depends on spmv_pkg and spmv_ram.
module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_LEN = spmv_pkg::VECTOR_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Row count register
  input  logic                               cfg_wr_en,
  input  logic [spmv_pkg::CNT_W-1:0]         cfg_wr_data,
  // Input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [spmv_pkg::IN_TDATA_W-1:0]    in_tdata,  // index[9:0], value[25:10], zeros
  input  logic [spmv_pkg::OP_W-1:0]          in_tuser,  // op[1:0]
  input  logic                               in_tlast,  // row_end
  // Result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [spmv_pkg::OUT_TDATA_W-1:0]   out_tdata  // row_number[9:0], row_sum[57:10], zeros
);

  localparam int AW = $clog2(VECTOR_LEN);

  // Input fields
  logic [spmv_pkg::INDEX_W-1:0]        in_index;
  logic signed [spmv_pkg::VALUE_W-1:0] in_value;
  logic [31:0]                         idx_ext;
  logic                                in_range;
  logic                                in_acc;
  logic [AW-1:0]                       ram_addr;
  logic                                ram_we;
  logic [spmv_pkg::VALUE_W-1:0]        ram_rdata;

  assign in_index = in_tdata[spmv_pkg::INDEX_W-1:0];
  assign in_value = in_tdata[spmv_pkg::INDEX_W +: spmv_pkg::VALUE_W];
  assign idx_ext  = 32'(in_index);
  assign in_range = idx_ext < 32'(VECTOR_LEN);
  assign ram_addr = idx_ext[AW-1:0];
  assign in_acc   = in_tvalid && in_tready;
  assign ram_we   = in_acc && (in_tuser == spmv_pkg::OP_LOAD) && in_range;

  // Vector store. A load written at one edge is visible to a read issued at the next edge,
  // so back-to-back load and multiply on the same entry need no forwarding.
  spmv_ram #(
    .WIDTH (spmv_pkg::VALUE_W),
    .DEPTH (VECTOR_LEN)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (in_value),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Stage 1: vector entry arrives from the RAM
  logic                                s1_valid_r;
  logic                                s1_nz_r;
  logic                                s1_range_r;
  logic                                s1_close_r;
  logic signed [spmv_pkg::VALUE_W-1:0] s1_value_r;
  logic                                is_nz;
  logic                                is_close_op;

  assign is_nz       = in_tuser == spmv_pkg::OP_NONZERO;
  assign is_close_op = in_tuser == spmv_pkg::OP_CLOSE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc && (is_nz || is_close_op);
    end
    s1_nz_r    <= is_nz;
    s1_range_r <= in_range;
    s1_close_r <= is_close_op || (is_nz && in_tlast);
    s1_value_r <= in_value;
  end

  // Stage 2: product of the nonzero and the vector entry; zero for a close or an out-of-range index
  logic signed [spmv_pkg::VALUE_W-1:0] vec_val;
  logic signed [spmv_pkg::PROD_W-1:0]  prod_nxt;
  logic                                s2_valid_r;
  logic                                s2_close_r;
  logic signed [spmv_pkg::PROD_W-1:0]  s2_prod_r;

  assign vec_val  = (s1_nz_r && s1_range_r) ? $signed(ram_rdata) : '0;
  assign prod_nxt = 32'(s1_value_r) * 32'(vec_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_close_r <= s1_close_r;
    s2_prod_r  <= prod_nxt;
  end

  // Stage 3: saturating accumulate and row close
  logic signed [spmv_pkg::SUM_W-1:0] acc_r;
  logic signed [spmv_pkg::SUM_W-1:0] acc_nxt;
  logic signed [spmv_pkg::SUM_W:0]   sum_wide;
  logic signed [spmv_pkg::SUM_W-1:0] sum_sat;
  logic [spmv_pkg::ROW_W-1:0]        row_r;
  logic [spmv_pkg::ROW_W-1:0]        row_nxt;
  logic [spmv_pkg::CNT_W-1:0]        row_inc;
  logic [spmv_pkg::CNT_W-1:0]        rows_in_use_r;
  logic                              push;

  assign sum_wide = (spmv_pkg::SUM_W + 1)'(acc_r) + (spmv_pkg::SUM_W + 1)'(s2_prod_r);

  always_comb begin
    if (sum_wide[spmv_pkg::SUM_W] != sum_wide[spmv_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[spmv_pkg::SUM_W] ? spmv_pkg::SUM_MIN : spmv_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[spmv_pkg::SUM_W-1:0];
    end
  end

  assign push    = s2_valid_r && s2_close_r;
  assign row_inc = {1'b0, row_r} + 11'd1;

  // The row counter wraps at the row count or past the last row number
  always_comb begin
    acc_nxt = acc_r;
    row_nxt = row_r;
    if (s2_valid_r) begin
      if (s2_close_r) begin
        acc_nxt = '0;
        if (row_inc >= rows_in_use_r || row_inc[spmv_pkg::CNT_W-1]) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_inc[spmv_pkg::ROW_W-1:0];
        end
      end else begin
        acc_nxt = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= '0;
      row_r         <= '0;
      rows_in_use_r <= spmv_pkg::ROWS_RESET;
    end else begin
      acc_r <= acc_nxt;
      row_r <= row_nxt;
      if (cfg_wr_en) begin
        rows_in_use_r <= cfg_wr_data;
      end
    end
  end

  // Result queue
  spmv_pkg::result_t           q_mem_r [spmv_pkg::QDEPTH];
  spmv_pkg::result_t           q_head;
  logic [spmv_pkg::QAW-1:0]    wr_ptr_r;
  logic [spmv_pkg::QAW-1:0]    rd_ptr_r;
  logic [spmv_pkg::QCNT_W-1:0] q_count_r;
  logic                        pop;

  assign pop    = out_tvalid && out_tready;
  assign q_head = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      q_count_r <= q_count_r + spmv_pkg::QCNT_W'(push) - spmv_pkg::QCNT_W'(pop);
    end
    if (push) begin
      q_mem_r[wr_ptr_r].row_sum    <= s2_close_r ? sum_sat : acc_r;
      q_mem_r[wr_ptr_r].row_number <= row_r;
    end
  end

  // Admit an item only while every result in flight is sure of a queue slot
  logic [spmv_pkg::QCNT_W:0] pending;

  assign pending   = (spmv_pkg::QCNT_W + 1)'(q_count_r)
                   + (spmv_pkg::QCNT_W + 1)'(s1_valid_r && s1_close_r)
                   + (spmv_pkg::QCNT_W + 1)'(push);
  assign in_tready = pending < (spmv_pkg::QCNT_W + 1)'(spmv_pkg::QDEPTH);

  assign out_tvalid = q_count_r != '0;
  assign out_tdata  = {{(spmv_pkg::OUT_TDATA_W - spmv_pkg::SUM_W - spmv_pkg::ROW_W){1'b0}},
                       q_head.row_sum, q_head.row_number};

endmodule

// ===== hdl/spmv_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module spmv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read-first registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/spmv_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sparse matrix-vector multiply block, bound to the top level.
// Depends on spmv_pkg.
module spmv_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [spmv_pkg::OP_W-1:0]        in_tuser,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [spmv_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                         in_acc;
  logic                         out_acc;
  logic                         closes;
  logic [3:0]                   owed_r;
  logic [spmv_pkg::ROW_W-1:0]   last_row_r;
  logic                         seen_r;
  logic [spmv_pkg::ROW_W-1:0]   out_row;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign closes  = in_acc && ((in_tuser == spmv_pkg::OP_CLOSE)
                   || (in_tuser == spmv_pkg::OP_NONZERO && in_tlast));
  assign out_row = out_tdata[spmv_pkg::ROW_W-1:0];

  // Results owed for closing items accepted, and the last row number delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
      seen_r <= 1'b0;
    end else begin
      owed_r <= owed_r + 4'(closes) - 4'(out_acc);
      if (out_acc) begin
        seen_r <= 1'b1;
      end
    end
    if (out_acc) begin
      last_row_r <= out_row;
    end
  end

  // A stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No result without a closing item accepted before it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> owed_r != 4'd0)
    else $error("result without a closed row");

  // Results owed for closed rows never exceed the result queue depth
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r <= 4'(spmv_pkg::QDEPTH))
    else $error("more rows closed than the queue holds");

  // Row numbers step by one or wrap to zero
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r |-> out_row == last_row_r + 1'b1 || out_row == '0)
    else $error("row number out of sequence");

endmodule

bind csr_sparse_matrix_vector_multiply spmv_chk u_spmv_chk (.*);

// ===== sim/csr_sparse_matrix_vector_multiply_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the row-compressed sparse matrix-vector multiply block.
// Uses a table of directed items, then random row sequences under several row counts.
// Depends on spmv_pkg and on csr_sparse_matrix_vector_multiply with its vector RAM.
module csr_sparse_matrix_vector_multiply_tb;
  import spmv_pkg::*;

  // The fourth item kind, which the block must ignore.
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  localparam int SETTLE_CYCLES = 8;
  localparam int SETTLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES   = 100;
  localparam int RANDOM_ITEMS  = 75;
  localparam logic [CNT_W-1:0] ROW_PLAN [5] = '{11'd1, 11'd1024, 11'd0, 11'd3, 11'd2047};

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    logic               last;
    logic               typed;
    result_t            want;
  } step_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;  // index[9:0], value[25:10], zeros
  logic [OP_W-1:0]        in_tuser    = '0;  // op[1:0]
  logic                   in_tlast    = 1'b0;  // row_end
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // row_number[9:0], row_sum[57:10], zeros

  // Predictor state: vector image, row accumulator, row pointer and row count.
  logic signed [VALUE_W-1:0] vec_image [VECTOR_LEN_DEF];
  bit                        vec_loaded [VECTOR_LEN_DEF];
  int                        loaded_cols [$];
  longint                    row_acc   = 0;
  logic [ROW_W-1:0]          row_ptr   = '0;
  logic [CNT_W-1:0]          rows_limit = ROWS_RESET;

  // Row results still owed by the block, oldest first.
  result_t rows_due [$];

  int  mismatches   = 0;
  int  rows_seen    = 0;
  int  items_sent   = 0;
  int  ignored_sent = 0;
  int  idle_max_in  = 9;
  int  idle_max_out = 9;
  bit  hold_req     = 1'b0;

  step_t directed_plan [20] = '{
    '{OP_LOAD,    10'd0,     16'h0100, 1'b0, 1'b0, '0},
    '{OP_LOAD,    10'd1023,  16'h8000, 1'b1, 1'b0, '0},
    '{OP_LOAD,    10'd5,     16'h7FFF, 1'b0, 1'b0, '0},
    '{OP_NONZERO, 10'd0,     16'h0100, 1'b0, 1'b0, '0},
    '{OP_NONZERO, 10'd1023,  16'h8000, 1'b1, 1'b1, '{48'sh0000_4001_0000, 10'd0}},
    '{OP_CLOSE,   10'd0,     16'h0000, 1'b0, 1'b1, '{48'sd0, 10'd1}},
    '{OP_IGNORED, 10'd5,     16'h1234, 1'b1, 1'b0, '0},
    '{OP_NONZERO, 10'd5,     16'h7FFF, 1'b1, 1'b1, '{48'sh0000_3FFF_0001, 10'd2}},
    '{OP_NONZERO, 10'd5,     16'h8000, 1'b0, 1'b0, '0},
    '{OP_CLOSE,   10'd0,     16'h0000, 1'b1, 1'b1, '{-48'sd1073709056, 10'd3}},
    '{OP_CLOSE,   10'd0,     16'h0000, 1'b0, 1'b1, '{48'sd0, 10'd0}},
    '{OP_LOAD,    10'd512,   16'hFFFF, 1'b0, 1'b0, '0},
    '{OP_NONZERO, 10'd512,   16'hFFFF, 1'b1, 1'b1, '{48'sd1, 10'd1}},
    '{OP_LOAD,    10'h2AA,   16'h5555, 1'b0, 1'b0, '0},
    '{OP_LOAD,    10'h155,   16'hAAAA, 1'b0, 1'b0, '0},
    '{OP_NONZERO, 10'h2AA,   16'hAAAA, 1'b0, 1'b0, '0},
    '{OP_NONZERO, 10'h155,   16'h5555, 1'b1, 1'b0, '0},
    '{OP_IGNORED, 10'h3FF,   16'hFFFF, 1'b0, 1'b0, '0},
    '{OP_NONZERO, 10'd1023,  16'h7FFF, 1'b0, 1'b0, '0},
    '{OP_NONZERO, 10'd0,     16'h8000, 1'b1, 1'b0, '0}
  };

  csr_sparse_matrix_vector_multiply DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Overall time limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Run timed out with %0d row results outstanding.", rows_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch at %0t: %s: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Applies one accepted item to the predictor and queues the row it closes, if any.
  function automatic void accumulate_item(input logic [OP_W-1:0] op,
                                          input logic [INDEX_W-1:0] idx,
                                          input logic [VALUE_W-1:0] val,
                                          input logic last, input logic typed,
                                          input result_t want);
    longint  total;
    int      nxt;
    bit      closes;
    result_t row;
    closes = 1'b0;
    case (op)
      OP_LOAD: begin
        vec_image[idx] = $signed(val);
        if (!vec_loaded[idx]) begin
          vec_loaded[idx] = 1'b1;
          loaded_cols.push_back(int'(idx));
        end
      end
      OP_NONZERO: begin
        total = row_acc + longint'($signed(val)) * longint'(vec_image[idx]);
        if (total > longint'(SUM_MAX)) total = longint'(SUM_MAX);
        if (total < longint'(SUM_MIN)) total = longint'(SUM_MIN);
        row_acc = total;
        closes = last;
      end
      OP_CLOSE: closes = 1'b1;
      default: ;
    endcase
    if (closes) begin
      row.row_number = row_ptr;
      row.row_sum    = row_acc[SUM_W-1:0];
      rows_due.push_back(typed ? want : row);
      row_acc = 0;
      nxt = int'(row_ptr) + 1;
      if (nxt >= int'(rows_limit) || nxt > 1023) nxt = 0;
      row_ptr = ROW_W'(nxt);
    end
  endfunction

  // Offers one item after a random gap and waits for it to be taken.
  task automatic push_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] val, input logic last,
                           input logic typed = 1'b0, input result_t want = '0);
    int gap;
    gap = $urandom_range(0, idle_max_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, idx};
    in_tuser  <= op;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    accumulate_item(op, idx, val, last, typed, want);
    if (op == OP_IGNORED) ignored_sent++;
    else items_sent++;
  endtask

  // Stops offering items, waits for every owed row, then lets the pipeline empty.
  task automatic settle();
    int guard;
    in_tvalid <= 1'b0;
    for (guard = 0; rows_due.size() != 0 && guard < SETTLE_LIMIT; guard++)
      @(posedge clk);
    while (rows_due.size() != 0)
      flag_mismatch("row never produced", 64'(rows_due.pop_front()), '0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the row count register; only called while the block is idle.
  task automatic write_rows(input logic [CNT_W-1:0] count);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    rows_limit = count;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Only columns already loaded are ever read back.
  function automatic logic [INDEX_W-1:0] loaded_column();
    return INDEX_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
  endfunction

  // One random sequence: mostly well-formed rows, with loads, noise and open rows mixed in.
  task automatic random_sequence();
    int pick, n, k;
    bit by_close;
    logic [INDEX_W-1:0] col;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
        col = $urandom_range(0, 1) ? INDEX_W'($urandom) : INDEX_W'($urandom_range(0, 31));
        push_item(OP_LOAD, col, random_value(), 1'($urandom));
      end
    end else if (pick < 80) begin
      n = $urandom_range(0, 6);
      by_close = (n == 0) || ($urandom_range(0, 3) == 0);
      for (k = 0; k < n; k++)
        push_item(OP_NONZERO, loaded_column(), random_value(), !by_close && (k == n - 1));
      if (by_close)
        push_item(OP_CLOSE, INDEX_W'($urandom), VALUE_W'($urandom), 1'($urandom));
    end else if (pick < 90) begin
      push_item(OP_IGNORED, INDEX_W'($urandom), VALUE_W'($urandom), 1'($urandom));
    end else begin
      // A row left open: the next sequence keeps adding to it.
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++)
        push_item(OP_NONZERO, loaded_column(), random_value(), 1'b0);
    end
  endtask

  // Result side: random stalls, the long hold-off, and the check of each row.
  initial begin : result_sink
    int      stall_left;
    int      hold_left;
    result_t want;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        rows_seen++;
        if (rows_due.size() == 0) begin
          flag_mismatch("row with none owed", '0, out_tdata);
        end else begin
          want = rows_due.pop_front();
          if (out_tdata[ROW_W-1:0] !== want.row_number)
            flag_mismatch("row_number", 64'(want.row_number), 64'(out_tdata[ROW_W-1:0]));
          if (out_tdata[ROW_W+SUM_W-1:ROW_W] !== want.row_sum)
            flag_mismatch("row_sum", 64'(want.row_sum), 64'(out_tdata[ROW_W+SUM_W-1:ROW_W]));
        end
        stall_left = $urandom_range(0, idle_max_out);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Item side: reset, directed table, then random phases per row count.
  initial begin : item_source
    int p, k, start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items run with the row count left at its reset value.
    for (k = 0; k < 20; k++)
      push_item(directed_plan[k].op, directed_plan[k].idx, directed_plan[k].val,
                directed_plan[k].last, directed_plan[k].typed, directed_plan[k].want);
    settle();

    for (p = 0; p < 6; p++) begin
      write_rows(p == 5 ? CNT_W'($urandom_range(5, 1023)) : ROW_PLAN[p]);
      idle_max_in  = (p == 3) ? 0 : 9;
      idle_max_out = (p == 3) ? 0 : 9;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS)
        random_sequence();
      if (p == 1) begin
        // Output held off while single-item rows keep arriving back to back.
        hold_req    = 1'b1;
        idle_max_in = 0;
        for (k = 0; k < 24; k++)
          push_item(OP_NONZERO, loaded_column(), random_value(), 1'b1);
        idle_max_in = 9;
      end
      settle();
    end

    $display("Covered %0d items and %0d ignored ones, %0d rows checked, row counts 4, 1,",
             items_sent, ignored_sent, rows_seen);
    $display("1024, 0, 3, 2047 and one random, plus a long output hold with a full queue.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/spmv_pkg.sv
hdl/spmv_ram.sv
hdl/csr_sparse_matrix_vector_multiply.sv
hdl/spmv_chk.sv
sim/csr_sparse_matrix_vector_multiply_tb.sv
